>>> rtl/core/jetl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jetl_pkg
// Shared types, codes and constants of the Exif thumbnail locator.
// ---------------------------------------------------------------------------
package jetl_pkg;

    localparam int HEADER_BYTES_DEF = 65536;
    localparam int POS_W            = 36;

    localparam logic [7:0]  MK_PREFIX = 8'hFF;
    localparam logic [15:0] MK_SOI_W  = 16'hFFD8;
    localparam logic [7:0]  MK_APP1   = 8'hE1;
    localparam logic [7:0]  MK_SOS    = 8'hDA;
    localparam logic [7:0]  MK_EOI    = 8'hD9;
    localparam logic [7:0]  MK_SOF0   = 8'hC0;
    localparam logic [7:0]  MK_SOF1   = 8'hC1;
    localparam logic [7:0]  MK_SOF2   = 8'hC2;
    localparam logic [31:0] EXIF_HI   = 32'h45786966;
    localparam logic [15:0] BOM_MM    = 16'h4D4D;
    localparam logic [15:0] BOM_II    = 16'h4949;
    localparam logic [15:0] TIFF_MAGIC = 16'd42;
    localparam logic [15:0] TAG_ORIENT = 16'h0112;
    localparam logic [15:0] TAG_TOFF   = 16'h0201;
    localparam logic [15:0] TAG_TLEN   = 16'h0202;
    localparam logic [15:0] TYPE_SHORT = 16'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NO_SOI  = 3'd1;
    localparam logic [2:0] ERR_TIFF    = 3'd2;
    localparam logic [2:0] ERR_MISSING = 3'd3;
    localparam logic [2:0] ERR_RANGE   = 3'd4;

    typedef enum logic [4:0] {
        ST_LOAD, ST_SOI, ST_SOI_W, ST_SEG, ST_SEG_W, ST_SEG_CHK, ST_SOF_W,
        ST_EX1_W, ST_EX2_W, ST_T0, ST_T0_W, ST_T1_W, ST_T2_W, ST_I0, ST_I0_W,
        ST_E0, ST_E0_W, ST_E1, ST_E1_W, ST_NX, ST_NX_W, ST_TEND, ST_FINAL,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_FETCH_SOI, OP_ERR_SOI, OP_ERR_TIFF, OP_FETCH_SEG,
        OP_POS_INC, OP_SKIP, OP_FETCH_EX1, OP_FETCH_EX2, OP_FETCH_SOF,
        OP_APPLY_SOF, OP_ADVANCE, OP_TIFF_INIT, OP_FETCH_BOM, OP_BOM,
        OP_FETCH_IFDPTR, OP_SET_IFD, OP_FETCH_CNT, OP_SET_CNT, OP_FETCH_ENT,
        OP_SET_ENT, OP_FETCH_VAL, OP_ENT_NEXT, OP_APPLY_ENT, OP_FETCH_NXT,
        OP_SET_NXT0, OP_SET_NXT, OP_EXIF_DONE, OP_FINAL, OP_EMIT
    } t_op;

    typedef struct packed {
        logic last_in;
        logic fetch_done;
        logic soi_small;
        logic soi_ok;
        logic seg_go;
        logic not_ff;
        logic fill;
        logic stop;
        logic len_bad;
        logic exif_cand;
        logic is_sof;
        logic ex1_ok;
        logic ex2_ok;
        logic lim_small;
        logic bom_ok;
        logic w42;
        logic ifd_end;
        logic cnt_ok;
        logic ent_done;
        logic ent_ok;
        logic val_ok;
        logic nxt_ok;
        logic thumb_ok;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

>>> rtl/core/jpeg_exif_thumbnail_locator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpeg_exif_thumbnail_locator
// Locates the Exif thumbnail and frame size within a buffered JPEG header.
// ---------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one header byte per cycle while the
// block is loading; i_last_byte marks the final byte of a header. Bytes past
// HEADER_BYTES are accepted and dropped; a last byte among them still parses.
// After the last byte the sequencer walks the marker segments and the TIFF
// IFDs, reading each 2- or 4-byte field from the header store one byte per
// cycle through its single read port.
// Then one result request appears on o_valid/i_ready with status,
// orientation, thumbnail position and length, and frame size.
// The result sits in an output register: loading of the next header starts
// at once, and only the next result waits if the receiver stalls.
// Reset clears the byte count and the result valid; the store is not cleared.
// ---------------------------------------------------------------------------
module jpeg_exif_thumbnail_locator #(
    parameter int HEADER_BYTES = jetl_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_header_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_orientation,
    output logic [15:0] o_thumb_start,
    output logic [16:0] o_thumb_length,
    output logic [15:0] o_frame_width,
    output logic [15:0] o_frame_height
);
    jetl_pkg::t_op  op;
    jetl_pkg::t_sts sts;

    jetl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_op    (op)
    );

    jetl_datapath #(.HEADER_BYTES(HEADER_BYTES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_sts          (sts),
        .i_valid        (i_valid),
        .i_header_byte  (i_header_byte),
        .i_last_byte    (i_last_byte),
        .o_ready        (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_orientation  (o_orientation),
        .o_thumb_start  (o_thumb_start),
        .o_thumb_length (o_thumb_length),
        .o_frame_width  (o_frame_width),
        .o_frame_height (o_frame_height)
    );
endmodule

>>> rtl/core/jetl_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jetl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module jetl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jetl_pkg::HEADER_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/jetl_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jetl_datapath
// Header store, byte fetch engine, parse registers and result register.
// ---------------------------------------------------------------------------
module jetl_datapath #(
    parameter int HEADER_BYTES = jetl_pkg::HEADER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jetl_pkg::t_op  i_op,
    output jetl_pkg::t_sts o_sts,
    input  logic           i_valid,
    input  logic [7:0]     i_header_byte,
    input  logic           i_last_byte,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_status,
    output logic [3:0]     o_orientation,
    output logic [15:0]    o_thumb_start,
    output logic [16:0]    o_thumb_length,
    output logic [15:0]    o_frame_width,
    output logic [15:0]    o_frame_height
);
    localparam int AW = $clog2(HEADER_BYTES);
    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam int PW = jetl_pkg::POS_W;

    logic [CW-1:0] r_count;
    logic [PW-1:0] r_fa, r_pos, r_tiff, r_lim, r_e, r_naddr;
    logic [2:0]    r_iss;
    logic          r_rdv, r_done;
    logic [31:0]   r_acc, r_ifd, r_orient, r_toff, r_tlen;
    logic [15:0]   r_seg_len, r_cnt, r_i, r_tag, r_typ, r_fw, r_fh;
    logic [1:0]    r_k;
    logic          r_big, r_have_exif, r_have_frame;
    logic [2:0]    r_err;
    logic          r_out_valid;
    logic [2:0]    r_o_status;
    logic [3:0]    r_o_orient;
    logic [15:0]   r_o_start, r_o_fw, r_o_fh;
    logic [16:0]   r_o_len;

    logic [7:0]    rdata;
    logic          we;
    logic          f_start;
    logic [PW-1:0] f_addr;
    logic [2:0]    f_n;
    logic [PW-1:0] size, seg_len, start;
    logic [15:0]   v16;
    logic [31:0]   v32, val;
    logic [7:0]    b0, b1;

    assign we      = (i_op == jetl_pkg::OP_LOAD) && i_valid
                     && (r_count < CW'(HEADER_BYTES));
    assign o_ready = (i_op == jetl_pkg::OP_LOAD);

    jetl_ram #(.WIDTH(8), .DEPTH(HEADER_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_header_byte),
        .i_raddr (r_fa[AW-1:0]),
        .o_rdata (rdata)
    );

    assign size    = PW'(r_count);
    assign seg_len = PW'(r_acc[15:0]);
    assign b0      = r_acc[31:24];
    assign b1      = r_acc[23:16];
    assign v16     = r_big ? r_acc[15:0] : jetl_pkg::swap16(r_acc[15:0]);
    assign v32     = r_big ? r_acc : {r_acc[7:0], r_acc[15:8], r_acc[23:16], r_acc[31:24]};
    assign val     = (r_typ == jetl_pkg::TYPE_SHORT) ? {16'd0, v16} : v32;
    assign start   = r_tiff + PW'(r_toff);

    always_comb begin
        f_start = 1'b1;
        f_addr  = '0;
        f_n     = 3'd4;
        unique case (i_op)
            jetl_pkg::OP_FETCH_SOI: begin
                f_n = 3'd2;
            end
            jetl_pkg::OP_FETCH_SEG:    f_addr = r_pos;
            jetl_pkg::OP_FETCH_EX1:    f_addr = r_pos + PW'(4);
            jetl_pkg::OP_FETCH_EX2: begin
                f_addr = r_pos + PW'(8);
                f_n    = 3'd2;
            end
            jetl_pkg::OP_FETCH_SOF:    f_addr = r_pos + PW'(5);
            jetl_pkg::OP_FETCH_BOM: begin
                f_addr = r_tiff;
                f_n    = 3'd2;
            end
            jetl_pkg::OP_BOM: begin
                f_addr = r_tiff + PW'(2);
                f_n    = 3'd2;
            end
            jetl_pkg::OP_FETCH_IFDPTR: f_addr = r_tiff + PW'(4);
            jetl_pkg::OP_FETCH_CNT: begin
                f_addr = r_tiff + PW'(r_ifd);
                f_n    = 3'd2;
            end
            jetl_pkg::OP_FETCH_ENT:    f_addr = r_tiff + r_e;
            jetl_pkg::OP_FETCH_VAL: begin
                f_addr = r_tiff + r_e + PW'(8);
                f_n    = (r_typ == jetl_pkg::TYPE_SHORT) ? 3'd2 : 3'd4;
            end
            jetl_pkg::OP_FETCH_NXT:    f_addr = r_tiff + r_naddr;
            default:                   f_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss  <= '0;
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_rdv && (r_iss == 3'd0);
            if (f_start) begin
                r_iss <= f_n;
                r_rdv <= 1'b0;
            end else if (r_iss != 3'd0) begin
                r_iss <= r_iss - 3'd1;
                r_rdv <= 1'b1;
            end else begin
                r_rdv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_start) begin
            r_fa <= f_addr;
        end else if (r_iss != 3'd0) begin
            r_fa <= r_fa + PW'(1);
        end
        if (r_rdv) begin
            r_acc <= {r_acc[23:0], rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_have_exif  <= 1'b0;
            r_have_frame <= 1'b0;
        end else begin
            if (i_op == jetl_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op) inside
                jetl_pkg::OP_LOAD: begin
                    if (we) r_count <= r_count + CW'(1);
                end
                jetl_pkg::OP_FETCH_SOI: begin
                    r_pos        <= PW'(2);
                    r_have_exif  <= 1'b0;
                    r_have_frame <= 1'b0;
                    r_orient     <= 32'd1;
                    r_toff       <= '0;
                    r_tlen       <= '0;
                    r_fw         <= '0;
                    r_fh         <= '0;
                    r_err        <= jetl_pkg::ERR_NONE;
                end
                jetl_pkg::OP_ERR_SOI:  r_err <= jetl_pkg::ERR_NO_SOI;
                jetl_pkg::OP_ERR_TIFF: r_err <= jetl_pkg::ERR_TIFF;
                jetl_pkg::OP_POS_INC:  r_pos <= r_pos + PW'(1);
                jetl_pkg::OP_SKIP:     r_pos <= r_pos + PW'(2) + seg_len;
                jetl_pkg::OP_FETCH_EX1, jetl_pkg::OP_FETCH_SOF: begin
                    r_seg_len <= r_acc[15:0];
                end
                jetl_pkg::OP_APPLY_SOF: begin
                    r_fh         <= r_acc[31:16];
                    r_fw         <= r_acc[15:0];
                    r_have_frame <= 1'b1;
                    r_pos        <= r_pos + PW'(2) + PW'(r_seg_len);
                end
                jetl_pkg::OP_ADVANCE: r_pos <= r_pos + PW'(2) + PW'(r_seg_len);
                jetl_pkg::OP_TIFF_INIT: begin
                    r_tiff <= r_pos + PW'(10);
                    r_lim  <= PW'(r_seg_len) - PW'(8);
                end
                jetl_pkg::OP_BOM: r_big <= (r_acc[15:0] == jetl_pkg::BOM_MM);
                jetl_pkg::OP_SET_IFD: begin
                    r_ifd <= v32;
                    r_k   <= 2'd0;
                end
                jetl_pkg::OP_SET_CNT: begin
                    r_cnt   <= v16;
                    r_i     <= '0;
                    r_e     <= PW'(r_ifd) + PW'(2);
                    r_naddr <= PW'(r_ifd) + PW'(2) + (PW'(v16) << 3) + (PW'(v16) << 2);
                end
                jetl_pkg::OP_SET_ENT: begin
                    r_tag <= r_big ? r_acc[31:16] : jetl_pkg::swap16(r_acc[31:16]);
                    r_typ <= r_big ? r_acc[15:0] : jetl_pkg::swap16(r_acc[15:0]);
                end
                jetl_pkg::OP_ENT_NEXT: begin
                    r_i <= r_i + 16'd1;
                    r_e <= r_e + PW'(12);
                end
                jetl_pkg::OP_APPLY_ENT: begin
                    if (r_k == 2'd0 && r_tag == jetl_pkg::TAG_ORIENT) r_orient <= val;
                    else if (r_k == 2'd1 && r_tag == jetl_pkg::TAG_TOFF) r_toff <= val;
                    else if (r_k == 2'd1 && r_tag == jetl_pkg::TAG_TLEN) r_tlen <= val;
                    r_i <= r_i + 16'd1;
                    r_e <= r_e + PW'(12);
                end
                jetl_pkg::OP_SET_NXT0: begin
                    r_ifd <= '0;
                    r_k   <= r_k + 2'd1;
                end
                jetl_pkg::OP_SET_NXT: begin
                    r_ifd <= v32;
                    r_k   <= r_k + 2'd1;
                end
                jetl_pkg::OP_EXIF_DONE: begin
                    r_have_exif <= 1'b1;
                    r_pos       <= r_pos + PW'(2) + PW'(r_seg_len);
                end
                jetl_pkg::OP_FINAL: begin
                    if (!(r_have_exif && r_have_frame)) r_err <= jetl_pkg::ERR_MISSING;
                    else if (start + PW'(r_tlen) > size) r_err <= jetl_pkg::ERR_RANGE;
                    else r_err <= jetl_pkg::ERR_NONE;
                end
                jetl_pkg::OP_EMIT: begin
                    r_count     <= '0;
                    r_o_status  <= r_err;
                    if (r_err == jetl_pkg::ERR_NONE) begin
                        r_o_orient <= (r_orient >= 32'd2 && r_orient <= 32'd8)
                                      ? r_orient[3:0] : 4'd1;
                        r_o_start  <= start[15:0];
                        r_o_len    <= r_tlen[16:0];
                        r_o_fw     <= r_fw;
                        r_o_fh     <= r_fh;
                    end else begin
                        r_o_orient <= 4'd1;
                        r_o_start  <= '0;
                        r_o_len    <= '0;
                        r_o_fw     <= '0;
                        r_o_fh     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.last_in    = i_valid && i_last_byte;
        o_sts.fetch_done = r_done;
        o_sts.soi_small  = r_count < CW'(4);
        o_sts.soi_ok     = r_acc[15:0] == jetl_pkg::MK_SOI_W;
        o_sts.seg_go     = (r_pos + PW'(4) <= size) && !(r_have_exif && r_have_frame);
        o_sts.not_ff     = b0 != jetl_pkg::MK_PREFIX;
        o_sts.fill       = b1 == jetl_pkg::MK_PREFIX;
        o_sts.stop       = (b1 == jetl_pkg::MK_SOS) || (b1 == jetl_pkg::MK_EOI);
        o_sts.len_bad    = (seg_len < PW'(2)) || (r_pos + PW'(2) + seg_len > size);
        o_sts.exif_cand  = (b1 == jetl_pkg::MK_APP1) && !r_have_exif && (seg_len >= PW'(8));
        o_sts.is_sof     = ((b1 == jetl_pkg::MK_SOF0) || (b1 == jetl_pkg::MK_SOF1)
                            || (b1 == jetl_pkg::MK_SOF2)) && (seg_len >= PW'(8));
        o_sts.ex1_ok     = r_acc == jetl_pkg::EXIF_HI;
        o_sts.ex2_ok     = r_acc[15:0] == 16'd0;
        o_sts.lim_small  = r_lim < PW'(8);
        o_sts.bom_ok     = (r_acc[15:0] == jetl_pkg::BOM_MM) || (r_acc[15:0] == jetl_pkg::BOM_II);
        o_sts.w42        = v16 == jetl_pkg::TIFF_MAGIC;
        o_sts.ifd_end    = (r_k == 2'd2) || (r_ifd == 32'd0);
        o_sts.cnt_ok     = PW'(r_ifd) + PW'(2) <= r_lim;
        o_sts.ent_done   = r_i == r_cnt;
        o_sts.ent_ok     = r_e + PW'(4) <= r_lim;
        o_sts.val_ok     = (r_typ == jetl_pkg::TYPE_SHORT) ? (r_e + PW'(10) <= r_lim)
                                                           : (r_e + PW'(12) <= r_lim);
        o_sts.nxt_ok     = r_naddr + PW'(4) <= r_lim;
        o_sts.thumb_ok   = (r_toff != 32'd0) && (r_tlen != 32'd0);
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_orientation  = r_o_orient;
    assign o_thumb_start  = r_o_start;
    assign o_thumb_length = r_o_len;
    assign o_frame_width  = r_o_fw;
    assign o_frame_height = r_o_fh;
endmodule

>>> rtl/core/jetl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jetl_ctrl
// Parse sequencer: walks markers and TIFF IFDs by issuing datapath commands.
// ---------------------------------------------------------------------------
module jetl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jetl_pkg::t_sts i_sts,
    output jetl_pkg::t_op  o_op
);
    jetl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jetl_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jetl_pkg::ST_LOAD:  if (i_sts.last_in) n_state = jetl_pkg::ST_SOI;
            jetl_pkg::ST_SOI:   n_state = i_sts.soi_small ? jetl_pkg::ST_DONE : jetl_pkg::ST_SOI_W;
            jetl_pkg::ST_SOI_W: if (i_sts.fetch_done) begin
                n_state = i_sts.soi_ok ? jetl_pkg::ST_SEG : jetl_pkg::ST_DONE;
            end
            jetl_pkg::ST_SEG:   n_state = i_sts.seg_go ? jetl_pkg::ST_SEG_W : jetl_pkg::ST_FINAL;
            jetl_pkg::ST_SEG_W: if (i_sts.fetch_done) n_state = jetl_pkg::ST_SEG_CHK;
            jetl_pkg::ST_SEG_CHK: begin
                if (i_sts.not_ff) n_state = jetl_pkg::ST_FINAL;
                else if (i_sts.fill) n_state = jetl_pkg::ST_SEG;
                else if (i_sts.stop || i_sts.len_bad) n_state = jetl_pkg::ST_FINAL;
                else if (i_sts.exif_cand) n_state = jetl_pkg::ST_EX1_W;
                else if (i_sts.is_sof) n_state = jetl_pkg::ST_SOF_W;
                else n_state = jetl_pkg::ST_SEG;
            end
            jetl_pkg::ST_SOF_W: if (i_sts.fetch_done) n_state = jetl_pkg::ST_SEG;
            jetl_pkg::ST_EX1_W: if (i_sts.fetch_done) begin
                n_state = i_sts.ex1_ok ? jetl_pkg::ST_EX2_W : jetl_pkg::ST_SEG;
            end
            jetl_pkg::ST_EX2_W: if (i_sts.fetch_done) begin
                n_state = i_sts.ex2_ok ? jetl_pkg::ST_T0 : jetl_pkg::ST_SEG;
            end
            jetl_pkg::ST_T0:    n_state = i_sts.lim_small ? jetl_pkg::ST_DONE : jetl_pkg::ST_T0_W;
            jetl_pkg::ST_T0_W:  if (i_sts.fetch_done) begin
                n_state = i_sts.bom_ok ? jetl_pkg::ST_T1_W : jetl_pkg::ST_DONE;
            end
            jetl_pkg::ST_T1_W:  if (i_sts.fetch_done) begin
                n_state = i_sts.w42 ? jetl_pkg::ST_T2_W : jetl_pkg::ST_DONE;
            end
            jetl_pkg::ST_T2_W:  if (i_sts.fetch_done) n_state = jetl_pkg::ST_I0;
            jetl_pkg::ST_I0: begin
                if (i_sts.ifd_end) n_state = jetl_pkg::ST_TEND;
                else n_state = i_sts.cnt_ok ? jetl_pkg::ST_I0_W : jetl_pkg::ST_DONE;
            end
            jetl_pkg::ST_I0_W:  if (i_sts.fetch_done) n_state = jetl_pkg::ST_E0;
            jetl_pkg::ST_E0: begin
                if (i_sts.ent_done || !i_sts.ent_ok) n_state = jetl_pkg::ST_NX;
                else n_state = jetl_pkg::ST_E0_W;
            end
            jetl_pkg::ST_E0_W:  if (i_sts.fetch_done) n_state = jetl_pkg::ST_E1;
            jetl_pkg::ST_E1:    n_state = i_sts.val_ok ? jetl_pkg::ST_E1_W : jetl_pkg::ST_E0;
            jetl_pkg::ST_E1_W:  if (i_sts.fetch_done) n_state = jetl_pkg::ST_E0;
            jetl_pkg::ST_NX:    n_state = i_sts.nxt_ok ? jetl_pkg::ST_NX_W : jetl_pkg::ST_I0;
            jetl_pkg::ST_NX_W:  if (i_sts.fetch_done) n_state = jetl_pkg::ST_I0;
            jetl_pkg::ST_TEND:  n_state = i_sts.thumb_ok ? jetl_pkg::ST_SEG : jetl_pkg::ST_DONE;
            jetl_pkg::ST_FINAL: n_state = jetl_pkg::ST_DONE;
            jetl_pkg::ST_DONE:  if (i_sts.out_free) n_state = jetl_pkg::ST_LOAD;
            default:            n_state = jetl_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_op = jetl_pkg::OP_NONE;
        unique case (r_state)
            jetl_pkg::ST_LOAD:  o_op = jetl_pkg::OP_LOAD;
            jetl_pkg::ST_SOI:   o_op = i_sts.soi_small ? jetl_pkg::OP_ERR_SOI
                                                       : jetl_pkg::OP_FETCH_SOI;
            jetl_pkg::ST_SOI_W: if (i_sts.fetch_done && !i_sts.soi_ok) o_op = jetl_pkg::OP_ERR_SOI;
            jetl_pkg::ST_SEG:   if (i_sts.seg_go) o_op = jetl_pkg::OP_FETCH_SEG;
            jetl_pkg::ST_SEG_CHK: begin
                if (i_sts.not_ff) o_op = jetl_pkg::OP_NONE;
                else if (i_sts.fill) o_op = jetl_pkg::OP_POS_INC;
                else if (i_sts.stop || i_sts.len_bad) o_op = jetl_pkg::OP_NONE;
                else if (i_sts.exif_cand) o_op = jetl_pkg::OP_FETCH_EX1;
                else if (i_sts.is_sof) o_op = jetl_pkg::OP_FETCH_SOF;
                else o_op = jetl_pkg::OP_SKIP;
            end
            jetl_pkg::ST_SOF_W: if (i_sts.fetch_done) o_op = jetl_pkg::OP_APPLY_SOF;
            jetl_pkg::ST_EX1_W: if (i_sts.fetch_done) begin
                o_op = i_sts.ex1_ok ? jetl_pkg::OP_FETCH_EX2 : jetl_pkg::OP_ADVANCE;
            end
            jetl_pkg::ST_EX2_W: if (i_sts.fetch_done) begin
                o_op = i_sts.ex2_ok ? jetl_pkg::OP_TIFF_INIT : jetl_pkg::OP_ADVANCE;
            end
            jetl_pkg::ST_T0:    o_op = i_sts.lim_small ? jetl_pkg::OP_ERR_TIFF
                                                       : jetl_pkg::OP_FETCH_BOM;
            jetl_pkg::ST_T0_W:  if (i_sts.fetch_done) begin
                o_op = i_sts.bom_ok ? jetl_pkg::OP_BOM : jetl_pkg::OP_ERR_TIFF;
            end
            jetl_pkg::ST_T1_W:  if (i_sts.fetch_done) begin
                o_op = i_sts.w42 ? jetl_pkg::OP_FETCH_IFDPTR : jetl_pkg::OP_ERR_TIFF;
            end
            jetl_pkg::ST_T2_W:  if (i_sts.fetch_done) o_op = jetl_pkg::OP_SET_IFD;
            jetl_pkg::ST_I0: begin
                if (!i_sts.ifd_end) begin
                    o_op = i_sts.cnt_ok ? jetl_pkg::OP_FETCH_CNT : jetl_pkg::OP_ERR_TIFF;
                end
            end
            jetl_pkg::ST_I0_W:  if (i_sts.fetch_done) o_op = jetl_pkg::OP_SET_CNT;
            jetl_pkg::ST_E0:    if (!i_sts.ent_done && i_sts.ent_ok) o_op = jetl_pkg::OP_FETCH_ENT;
            jetl_pkg::ST_E0_W:  if (i_sts.fetch_done) o_op = jetl_pkg::OP_SET_ENT;
            jetl_pkg::ST_E1:    o_op = i_sts.val_ok ? jetl_pkg::OP_FETCH_VAL
                                                    : jetl_pkg::OP_ENT_NEXT;
            jetl_pkg::ST_E1_W:  if (i_sts.fetch_done) o_op = jetl_pkg::OP_APPLY_ENT;
            jetl_pkg::ST_NX:    o_op = i_sts.nxt_ok ? jetl_pkg::OP_FETCH_NXT
                                                    : jetl_pkg::OP_SET_NXT0;
            jetl_pkg::ST_NX_W:  if (i_sts.fetch_done) o_op = jetl_pkg::OP_SET_NXT;
            jetl_pkg::ST_TEND:  o_op = i_sts.thumb_ok ? jetl_pkg::OP_EXIF_DONE
                                                      : jetl_pkg::OP_ERR_TIFF;
            jetl_pkg::ST_FINAL: o_op = jetl_pkg::OP_FINAL;
            jetl_pkg::ST_DONE:  if (i_sts.out_free) o_op = jetl_pkg::OP_EMIT;
            default:            o_op = jetl_pkg::OP_NONE;
        endcase
    end
endmodule

>>> rtl/core/jetl_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jetl_checker
// Port-level checks of the thumbnail locator, bound to the top level.
// ---------------------------------------------------------------------------
module jetl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_header_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [3:0]  o_orientation,
    input logic [15:0] o_thumb_start,
    input logic [16:0] o_thumb_length,
    input logic [15:0] o_frame_width,
    input logic [15:0] o_frame_height
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != jetl_pkg::ERR_NONE |-> o_orientation == 4'd1
            && o_thumb_start == 16'd0 && o_thumb_length == 17'd0
            && o_frame_width == 16'd0 && o_frame_height == 16'd0)
        else $error("error result carries data");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == jetl_pkg::ERR_NONE |-> o_orientation >= 4'd1
            && o_orientation <= 4'd8)
        else $error("bad orientation on found result");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= jetl_pkg::ERR_RANGE)
        else $error("status code out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind jpeg_exif_thumbnail_locator jetl_checker u_jetl_checker (.*);
